/* design/landing_setpoint_predictor_macros.svh */
// Assertion macros used by the landing setpoint predictor checker.
`ifndef LANDING_SETPOINT_PREDICTOR_MACROS_SVH
`define LANDING_SETPOINT_PREDICTOR_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define LSP_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that holds in the cycle after the antecedent.
`define LSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Condition that holds in the cycle after reset is seen low.
`define LSP_ASSERT_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

/* design/lsp_pkg.sv */
// Shared types, constants and arithmetic helpers of the landing setpoint predictor.
package lsp_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_INDEX_W = 3;

    typedef logic signed [63:0] wide_t;

    // Intermediate saturation bound, +-(2^62 - 1)
    localparam wide_t LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] LIM65 = 65'sh0_3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] NLIM65 = -LIM65;
    localparam wide_t I32_MAX = 64'sd2147483647;
    localparam wide_t I32_MIN = -64'sd2147483648;

    // 0.0001 in Q16.16, rounded up to the next raw step
    localparam logic signed [31:0] SLOW_VEL = 32'sd7;

    // Product shifts
    localparam logic [4:0] SHIFT_NONE = 5'd0;
    localparam logic [4:0] SHIFT_Q16  = 5'd16;
    localparam logic [4:0] SHIFT_Q17  = 5'd17;

    typedef enum logic [1:0] {
        OP_PLATFORM = 2'd0,
        OP_VEHICLE  = 2'd1,
        OP_TICK     = 2'd2
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE      = 3'd0,
        CFG_PRED_GAIN = 3'd1,
        CFG_DIST_GAIN = 3'd2,
        CFG_MAX_NORM  = 3'd3,
        CFG_LIMIT_X   = 3'd4,
        CFG_LIMIT_Y   = 3'd5,
        CFG_DWELL     = 3'd6,
        CFG_PERIOD    = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic               detection_mode;
        logic signed [15:0] prediction_gain;
        logic signed [15:0] distance_gain;
        logic [30:0]        max_distance_norm;
        logic [30:0]        limit_x;
        logic [30:0]        limit_y;
        logic [31:0]        dwell_ticks;
        logic [30:0]        step_period;
    } cfg_t;

    typedef struct packed {
        op_t                kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [31:0]        now_time;
    } item_t;

    typedef struct packed {
        logic       start;
        wide_t      a;
        wide_t      b;
        logic [4:0] shift;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        wide_t       result;
        logic [63:0] raw_low;
    } mul_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] operand;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQ_X,
        ST_SQ_Y,
        ST_ROOT,
        ST_GAIN,
        ST_T2,
        ST_VT,
        ST_DVT,
        ST_GAP,
        ST_GREL,
        ST_EMIT
    } back_state_t;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_RUN,
        MUL_FIN
    } mul_state_t;

    typedef enum logic {
        SQ_IDLE,
        SQ_RUN
    } sqrt_state_t;

    // Add two bounded values, clamp to the intermediate range
    function automatic wide_t sat_add(input wide_t a, input wide_t b);
        logic signed [64:0] sum;
        sum = $signed({a[63], a}) + $signed({b[63], b});
        if (sum > LIM65)
            return LIM;
        else if (sum < NLIM65)
            return -LIM;
        else
            return sum[63:0];
    endfunction

    // Clamp to the 32-bit signed range
    function automatic logic signed [31:0] clamp32(input wide_t v);
        if (v > I32_MAX)
            return 32'sh7FFF_FFFF;
        else if (v < I32_MIN)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

/* design/lsp_front.sv */
// Front end: accepts input items, drops unused op codes, queues the rest.
module lsp_front #(
    parameter int DEPTH = lsp_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          op,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  vel_x,
    input  logic signed [31:0]  vel_y,
    input  logic [31:0]         now_time,
    output logic                q_valid,
    output lsp_pkg::item_t      q_item,
    input  logic                q_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lsp_pkg::item_t   entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             keep;
    logic             push;
    logic             pop;
    lsp_pkg::item_t   new_item;

    assign in_stall = (count_reg == CNT_W'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = entries_reg[rd_ptr_reg];
    assign pop      = q_valid & q_pop;

    // Classify the op code, drop codes with no meaning
    always_comb
    begin
        keep = 1'b0;
        new_item.kind = lsp_pkg::OP_PLATFORM;
        case (op)
            lsp_pkg::OP_PLATFORM:
            begin
                keep = 1'b1;
                new_item.kind = lsp_pkg::OP_PLATFORM;
            end
            lsp_pkg::OP_VEHICLE:
            begin
                keep = 1'b1;
                new_item.kind = lsp_pkg::OP_VEHICLE;
            end
            lsp_pkg::OP_TICK:
            begin
                keep = 1'b1;
                new_item.kind = lsp_pkg::OP_TICK;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
        new_item.pos_x    = pos_x;
        new_item.pos_y    = pos_y;
        new_item.vel_x    = vel_x;
        new_item.vel_y    = vel_y;
        new_item.now_time = now_time;
    end

    assign push = in_valid & ~in_stall & keep;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued payloads
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

/* design/lsp_mul.sv */
// Shared multiplier: 64x16 bits per step, truncating shift and saturation.
module lsp_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  lsp_pkg::mul_req_t req,
    output lsp_pkg::mul_rsp_t rsp
);

    localparam int DIGITS = 4;

    lsp_pkg::mul_state_t state_reg, state_next;
    logic                neg_reg, neg_next;
    logic [63:0]         mag_a_reg, mag_a_next;
    logic [63:0]         mag_b_reg, mag_b_next;
    logic [4:0]          shift_reg, shift_next;
    logic [127:0]        acc_reg, acc_next;
    logic [1:0]          step_reg, step_next;
    logic                done_reg, done_next;
    lsp_pkg::wide_t      result_reg, result_next;
    logic [63:0]         raw_reg, raw_next;
    logic [15:0]         digit;
    logic [79:0]         partial;
    logic [127:0]        shifted;
    logic [127:0]        quot;
    logic [63:0]         mag;

    assign digit   = mag_b_reg[{step_reg, 4'b0000} +: 16];
    assign partial = mag_a_reg * digit;
    assign shifted = {48'b0, partial} << {step_reg, 4'b0000};
    assign quot    = acc_reg >> shift_reg;
    assign mag     = (quot > {64'b0, lsp_pkg::LIM}) ? lsp_pkg::LIM : quot[63:0];

    assign rsp.done    = done_reg;
    assign rsp.result  = result_reg;
    assign rsp.raw_low = raw_reg;

    always_comb
    begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        mag_a_next  = mag_a_reg;
        mag_b_next  = mag_b_reg;
        shift_next  = shift_reg;
        acc_next    = acc_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        raw_next    = raw_reg;
        case (state_reg)
            lsp_pkg::MUL_IDLE:
            begin
                // Latch sign and magnitudes
                if (req.start)
                begin
                    neg_next   = req.a[63] ^ req.b[63];
                    mag_a_next = req.a[63] ? 64'(-req.a) : 64'(req.a);
                    mag_b_next = req.b[63] ? 64'(-req.b) : 64'(req.b);
                    shift_next = req.shift;
                    acc_next   = '0;
                    step_next  = '0;
                    state_next = lsp_pkg::MUL_RUN;
                end
            end
            lsp_pkg::MUL_RUN:
            begin
                // Accumulate one 16-bit digit
                acc_next  = acc_reg + shifted;
                step_next = step_reg + 1'b1;
                if (step_reg == 2'(DIGITS - 1))
                begin
                    state_next = lsp_pkg::MUL_FIN;
                end
            end
            lsp_pkg::MUL_FIN:
            begin
                // Shift, saturate and apply the sign
                result_next = neg_reg ? -lsp_pkg::wide_t'(mag) : lsp_pkg::wide_t'(mag);
                raw_next    = acc_reg[63:0];
                done_next   = 1'b1;
                state_next  = lsp_pkg::MUL_IDLE;
            end
            default:
            begin
                state_next = lsp_pkg::MUL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsp_pkg::MUL_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        mag_a_reg  <= mag_a_next;
        mag_b_reg  <= mag_b_next;
        shift_reg  <= shift_next;
        acc_reg    <= acc_next;
        step_reg   <= step_next;
        result_reg <= result_next;
        raw_reg    <= raw_next;
    end

endmodule

/* design/lsp_sqrt.sv */
// Integer square root of a 64-bit value, one result bit per cycle.
module lsp_sqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  lsp_pkg::sqrt_req_t req,
    output lsp_pkg::sqrt_rsp_t rsp
);

    lsp_pkg::sqrt_state_t state_reg, state_next;
    logic [63:0]          x_reg, x_next;
    logic [63:0]          r_reg, r_next;
    logic [63:0]          place_reg, place_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [31:0]          root_reg, root_next;
    logic [63:0]          trial;

    assign trial    = r_reg + place_reg;
    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        r_next     = r_reg;
        place_next = place_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        root_next  = root_reg;
        case (state_reg)
            lsp_pkg::SQ_IDLE:
            begin
                if (req.start)
                begin
                    x_next     = req.operand;
                    r_next     = '0;
                    place_next = 64'h4000_0000_0000_0000;
                    cnt_next   = '0;
                    state_next = lsp_pkg::SQ_RUN;
                end
            end
            lsp_pkg::SQ_RUN:
            begin
                // Try one root bit
                if (x_reg >= trial)
                begin
                    x_next = x_reg - trial;
                    r_next = (r_reg >> 1) + place_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                place_next = place_reg >> 2;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    root_next  = r_next[31:0];
                    done_next  = 1'b1;
                    state_next = lsp_pkg::SQ_IDLE;
                end
            end
            default:
            begin
                state_next = lsp_pkg::SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsp_pkg::SQ_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        r_reg     <= r_next;
        place_reg <= place_next;
        cnt_reg   <= cnt_next;
        root_reg  <= root_next;
    end

endmodule

/* design/lsp_back.sv */
// Back end: tracker state, tick sequencer and result register.
module lsp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lsp_pkg::cfg_t       cfg,
    input  logic                q_valid,
    input  lsp_pkg::item_t      q_item,
    output logic                q_pop,
    output lsp_pkg::mul_req_t   mul_req,
    input  lsp_pkg::mul_rsp_t   mul_rsp,
    output lsp_pkg::sqrt_req_t  sqrt_req,
    input  lsp_pkg::sqrt_rsp_t  sqrt_rsp,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  setpoint_x,
    output logic signed [31:0]  setpoint_y
);

    lsp_pkg::back_state_t state_reg, state_next;
    logic signed [31:0]   platform_x_reg, platform_x_next;
    logic signed [31:0]   platform_y_reg, platform_y_next;
    logic signed [31:0]   vehicle_x_reg, vehicle_x_next;
    logic signed [31:0]   vehicle_y_reg, vehicle_y_next;
    logic signed [31:0]   vel_now_reg [2];
    logic signed [31:0]   vel_now_next [2];
    logic signed [31:0]   vel_before_reg [2];
    logic signed [31:0]   vel_before_next [2];
    logic signed [31:0]   held_reg [2];
    logic signed [31:0]   held_next [2];
    logic [31:0]          far_time_reg, far_time_next;
    logic                 seen_reg, seen_next;
    logic [31:0]          now_reg, now_next;
    logic signed [32:0]   dx_reg, dx_next;
    logic signed [32:0]   dy_reg, dy_next;
    logic [63:0]          sq_reg, sq_next;
    logic [31:0]          norm_reg, norm_next;
    logic signed [17:0]   g2_eff_reg, g2_eff_next;
    logic [45:0]          t2_reg, t2_next;
    lsp_pkg::wide_t       va_reg, va_next;
    lsp_pkg::wide_t       ap_reg, ap_next;
    lsp_pkg::wide_t       rel_reg, rel_next;
    lsp_pkg::wide_t       s1_reg, s1_next;
    logic                 axis_reg, axis_next;
    logic                 launched_reg, launched_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [31:0]   out_x_reg, out_x_next;
    logic signed [31:0]   out_y_reg, out_y_next;

    logic [32:0]          adx;
    logic [32:0]          ady;
    logic                 far_hit;
    logic                 near_hit;
    logic [31:0]          elapsed;
    logic                 dwell_done;
    logic                 moving;
    logic                 mul_state;
    logic signed [32:0]   dv;
    logic signed [31:0]   pos_sel;
    logic signed [32:0]   off_sel;
    logic signed [33:0]   gain_num;
    logic signed [33:0]   gain_adj;

    assign out_valid  = out_valid_reg;
    assign setpoint_x = out_x_reg;
    assign setpoint_y = out_y_reg;

    // Offset tests against the limits and the dwell timer
    assign adx        = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign ady        = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
    assign far_hit    = (adx > {2'b00, cfg.limit_x}) || (ady > {2'b00, cfg.limit_y});
    assign near_hit   = (adx < {2'b00, cfg.limit_x}) && (ady < {2'b00, cfg.limit_y});
    assign elapsed    = now_reg - far_time_reg;
    assign dwell_done = elapsed > cfg.dwell_ticks;
    assign moving     = (vel_before_reg[0] >= lsp_pkg::SLOW_VEL)
                     || (vel_before_reg[0] <= -lsp_pkg::SLOW_VEL)
                     || (vel_before_reg[1] >= lsp_pkg::SLOW_VEL)
                     || (vel_before_reg[1] <= -lsp_pkg::SLOW_VEL);

    // Per-axis operands
    assign dv      = $signed({vel_now_reg[axis_reg][31], vel_now_reg[axis_reg]})
                   - $signed({vel_before_reg[axis_reg][31], vel_before_reg[axis_reg]});
    assign pos_sel = axis_reg ? platform_y_reg : platform_x_reg;
    assign off_sel = axis_reg ? dy_reg : dx_reg;

    // Distance gain reduced by the norm, truncated toward zero
    assign gain_num = $signed({{2{cfg.distance_gain[15]}}, cfg.distance_gain, 16'h0000})
                    - $signed({2'b00, norm_reg});
    assign gain_adj = gain_num + (gain_num[33] ? 34'sd65535 : 34'sd0);

    assign mul_state = (state_reg == lsp_pkg::ST_SQ_X) || (state_reg == lsp_pkg::ST_SQ_Y)
                    || (state_reg == lsp_pkg::ST_T2) || (state_reg == lsp_pkg::ST_VT)
                    || (state_reg == lsp_pkg::ST_DVT) || (state_reg == lsp_pkg::ST_GAP)
                    || (state_reg == lsp_pkg::ST_GREL);

    // Select multiplier operands by step
    always_comb
    begin
        mul_req.start = mul_state & ~launched_reg;
        mul_req.a     = '0;
        mul_req.b     = '0;
        mul_req.shift = lsp_pkg::SHIFT_NONE;
        case (state_reg)
            lsp_pkg::ST_SQ_X:
            begin
                mul_req.a = {{31{dx_reg[32]}}, dx_reg};
                mul_req.b = {{31{dx_reg[32]}}, dx_reg};
            end
            lsp_pkg::ST_SQ_Y:
            begin
                mul_req.a = {{31{dy_reg[32]}}, dy_reg};
                mul_req.b = {{31{dy_reg[32]}}, dy_reg};
            end
            lsp_pkg::ST_T2:
            begin
                mul_req.a     = {33'b0, cfg.step_period};
                mul_req.b     = {33'b0, cfg.step_period};
                mul_req.shift = lsp_pkg::SHIFT_Q16;
            end
            lsp_pkg::ST_VT:
            begin
                mul_req.a     = {{32{vel_now_reg[axis_reg][31]}}, vel_now_reg[axis_reg]};
                mul_req.b     = {33'b0, cfg.step_period};
                mul_req.shift = lsp_pkg::SHIFT_Q16;
            end
            lsp_pkg::ST_DVT:
            begin
                mul_req.a     = {{31{dv[32]}}, dv};
                mul_req.b     = {18'b0, t2_reg};
                mul_req.shift = lsp_pkg::SHIFT_Q17;
            end
            lsp_pkg::ST_GAP:
            begin
                mul_req.a = {{48{cfg.prediction_gain[15]}}, cfg.prediction_gain};
                mul_req.b = ap_reg;
            end
            lsp_pkg::ST_GREL:
            begin
                mul_req.a = {{46{g2_eff_reg[17]}}, g2_eff_reg};
                mul_req.b = rel_reg;
            end
            default:
            begin
                mul_req.shift = lsp_pkg::SHIFT_NONE;
            end
        endcase
    end

    assign sqrt_req.start   = (state_reg == lsp_pkg::ST_ROOT) & ~launched_reg;
    assign sqrt_req.operand = sq_reg;

    // Sequence one item
    always_comb
    begin
        state_next         = state_reg;
        platform_x_next    = platform_x_reg;
        platform_y_next    = platform_y_reg;
        vehicle_x_next     = vehicle_x_reg;
        vehicle_y_next     = vehicle_y_reg;
        vel_now_next[0]    = vel_now_reg[0];
        vel_now_next[1]    = vel_now_reg[1];
        vel_before_next[0] = vel_before_reg[0];
        vel_before_next[1] = vel_before_reg[1];
        held_next[0]       = held_reg[0];
        held_next[1]       = held_reg[1];
        far_time_next      = far_time_reg;
        seen_next          = seen_reg;
        now_next           = now_reg;
        dx_next            = dx_reg;
        dy_next            = dy_reg;
        sq_next            = sq_reg;
        norm_next          = norm_reg;
        g2_eff_next        = g2_eff_reg;
        t2_next            = t2_reg;
        va_next            = va_reg;
        ap_next            = ap_reg;
        rel_next           = rel_reg;
        s1_next            = s1_reg;
        axis_next          = axis_reg;
        launched_next      = launched_reg | mul_req.start | sqrt_req.start;
        out_valid_next     = out_valid_reg & out_stall;
        out_x_next         = out_x_reg;
        out_y_next         = out_y_reg;
        q_pop              = 1'b0;

        case (state_reg)
            lsp_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_item.kind)
                        lsp_pkg::OP_PLATFORM:
                        begin
                            vel_before_next[0] = vel_now_reg[0];
                            vel_before_next[1] = vel_now_reg[1];
                            vel_now_next[0]    = q_item.vel_x;
                            vel_now_next[1]    = q_item.vel_y;
                            platform_x_next    = q_item.pos_x;
                            platform_y_next    = q_item.pos_y;
                            seen_next          = 1'b1;
                        end
                        lsp_pkg::OP_VEHICLE:
                        begin
                            vehicle_x_next = q_item.pos_x;
                            vehicle_y_next = q_item.pos_y;
                        end
                        lsp_pkg::OP_TICK:
                        begin
                            now_next = q_item.now_time;
                            dx_next  = $signed({platform_x_reg[31], platform_x_reg})
                                     - $signed({vehicle_x_reg[31], vehicle_x_reg});
                            dy_next  = $signed({platform_y_reg[31], platform_y_reg})
                                     - $signed({vehicle_y_reg[31], vehicle_y_reg});
                            if (!cfg.detection_mode)
                            begin
                                state_next = moving ? lsp_pkg::ST_CHECK : lsp_pkg::ST_EMIT;
                            end
                            else
                            begin
                                // Detection mode restarts from a zero setpoint
                                held_next[0] = '0;
                                held_next[1] = '0;
                                if (seen_reg)
                                begin
                                    state_next = lsp_pkg::ST_CHECK;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = lsp_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            lsp_pkg::ST_CHECK:
            begin
                if (far_hit)
                begin
                    held_next[0]  = platform_x_reg;
                    held_next[1]  = platform_y_reg;
                    far_time_next = now_reg;
                    state_next    = lsp_pkg::ST_EMIT;
                end
                else if (near_hit && dwell_done)
                begin
                    state_next = lsp_pkg::ST_SQ_X;
                end
                else if (near_hit)
                begin
                    held_next[0] = platform_x_reg;
                    held_next[1] = platform_y_reg;
                    state_next   = lsp_pkg::ST_EMIT;
                end
                else
                begin
                    // Offset on a limit: keep the held setpoint
                    state_next = lsp_pkg::ST_EMIT;
                end
            end
            lsp_pkg::ST_SQ_X:
            begin
                if (mul_rsp.done)
                begin
                    sq_next       = mul_rsp.raw_low;
                    launched_next = 1'b0;
                    state_next    = lsp_pkg::ST_SQ_Y;
                end
            end
            lsp_pkg::ST_SQ_Y:
            begin
                if (mul_rsp.done)
                begin
                    sq_next       = sq_reg + mul_rsp.raw_low;
                    launched_next = 1'b0;
                    state_next    = lsp_pkg::ST_ROOT;
                end
            end
            lsp_pkg::ST_ROOT:
            begin
                if (sqrt_rsp.done)
                begin
                    norm_next     = sqrt_rsp.root;
                    launched_next = 1'b0;
                    state_next    = lsp_pkg::ST_GAIN;
                end
            end
            lsp_pkg::ST_GAIN:
            begin
                if (norm_reg > {1'b0, cfg.max_distance_norm})
                begin
                    g2_eff_next = gain_adj[33:16];
                end
                else
                begin
                    g2_eff_next = {{2{cfg.distance_gain[15]}}, cfg.distance_gain};
                end
                state_next = lsp_pkg::ST_T2;
            end
            lsp_pkg::ST_T2:
            begin
                if (mul_rsp.done)
                begin
                    t2_next       = mul_rsp.result[45:0];
                    axis_next     = 1'b0;
                    launched_next = 1'b0;
                    state_next    = lsp_pkg::ST_VT;
                end
            end
            lsp_pkg::ST_VT:
            begin
                if (mul_rsp.done)
                begin
                    va_next       = mul_rsp.result;
                    launched_next = 1'b0;
                    state_next    = lsp_pkg::ST_DVT;
                end
            end
            lsp_pkg::ST_DVT:
            begin
                if (mul_rsp.done)
                begin
                    ap_next       = lsp_pkg::sat_add(va_reg, mul_rsp.result);
                    launched_next = 1'b0;
                    state_next    = lsp_pkg::ST_GAP;
                end
            end
            lsp_pkg::ST_GAP:
            begin
                if (mul_rsp.done)
                begin
                    s1_next       = lsp_pkg::sat_add({{32{pos_sel[31]}}, pos_sel},
                                                     mul_rsp.result);
                    rel_next      = lsp_pkg::sat_add({{31{off_sel[32]}}, off_sel}, ap_reg);
                    launched_next = 1'b0;
                    state_next    = lsp_pkg::ST_GREL;
                end
            end
            lsp_pkg::ST_GREL:
            begin
                if (mul_rsp.done)
                begin
                    held_next[axis_reg] =
                        lsp_pkg::clamp32(lsp_pkg::sat_add(s1_reg, mul_rsp.result));
                    launched_next = 1'b0;
                    if (!axis_reg)
                    begin
                        axis_next  = 1'b1;
                        state_next = lsp_pkg::ST_VT;
                    end
                    else
                    begin
                        state_next = lsp_pkg::ST_EMIT;
                    end
                end
            end
            lsp_pkg::ST_EMIT:
            begin
                // Load the result register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = held_reg[0];
                    out_y_next     = held_reg[1];
                    state_next     = lsp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= lsp_pkg::ST_IDLE;
            platform_x_reg    <= '0;
            platform_y_reg    <= '0;
            vehicle_x_reg     <= '0;
            vehicle_y_reg     <= '0;
            vel_now_reg[0]    <= '0;
            vel_now_reg[1]    <= '0;
            vel_before_reg[0] <= '0;
            vel_before_reg[1] <= '0;
            held_reg[0]       <= '0;
            held_reg[1]       <= '0;
            far_time_reg      <= '0;
            seen_reg          <= 1'b0;
            launched_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            platform_x_reg    <= platform_x_next;
            platform_y_reg    <= platform_y_next;
            vehicle_x_reg     <= vehicle_x_next;
            vehicle_y_reg     <= vehicle_y_next;
            vel_now_reg[0]    <= vel_now_next[0];
            vel_now_reg[1]    <= vel_now_next[1];
            vel_before_reg[0] <= vel_before_next[0];
            vel_before_reg[1] <= vel_before_next[1];
            held_reg[0]       <= held_next[0];
            held_reg[1]       <= held_next[1];
            far_time_reg      <= far_time_next;
            seen_reg          <= seen_next;
            launched_reg      <= launched_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Working values and result payload
    always_ff @(posedge clk)
    begin
        now_reg    <= now_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        sq_reg     <= sq_next;
        norm_reg   <= norm_next;
        g2_eff_reg <= g2_eff_next;
        t2_reg     <= t2_next;
        va_reg     <= va_next;
        ap_reg     <= ap_next;
        rel_reg    <= rel_next;
        s1_reg     <= s1_next;
        axis_reg   <= axis_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
    end

endmodule

/* design/landing_setpoint_predictor.sv */
// Top level of the landing setpoint predictor: register file, front, back and shared units.
// Platform and vehicle updates pass through the queue before they reach the tracker state.
// A tick with no prediction does not use the shared units; a predicting tick makes
// eleven passes through the shared 64x16 multiplier and one through the square root.
// Inputs are taken every cycle while the queue has room.
// Asynchronous active-low reset clears tracker state, the configuration registers and the queue at once.
module landing_setpoint_predictor #(
    parameter int QUEUE_DEPTH = lsp_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      op,
    input  logic signed [31:0]              pos_x,
    input  logic signed [31:0]              pos_y,
    input  logic signed [31:0]              vel_x,
    input  logic signed [31:0]              vel_y,
    input  logic [31:0]                     now_time,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [31:0]              setpoint_x,
    output logic signed [31:0]              setpoint_y,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lsp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data
);

    lsp_pkg::cfg_t      cfg_reg, cfg_next;
    logic               q_valid;
    lsp_pkg::item_t     q_item;
    logic               q_pop;
    lsp_pkg::mul_req_t  mul_req;
    lsp_pkg::mul_rsp_t  mul_rsp;
    lsp_pkg::sqrt_req_t sqrt_req;
    lsp_pkg::sqrt_rsp_t sqrt_rsp;

    assign cfg_ready = 1'b1;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (lsp_pkg::cfg_index_t'(cfg_index))
                lsp_pkg::CFG_MODE:      cfg_next.detection_mode    = cfg_data[0];
                lsp_pkg::CFG_PRED_GAIN: cfg_next.prediction_gain   = cfg_data[15:0];
                lsp_pkg::CFG_DIST_GAIN: cfg_next.distance_gain     = cfg_data[15:0];
                lsp_pkg::CFG_MAX_NORM:  cfg_next.max_distance_norm = cfg_data[30:0];
                lsp_pkg::CFG_LIMIT_X:   cfg_next.limit_x           = cfg_data[30:0];
                lsp_pkg::CFG_LIMIT_Y:   cfg_next.limit_y           = cfg_data[30:0];
                lsp_pkg::CFG_DWELL:     cfg_next.dwell_ticks       = cfg_data;
                lsp_pkg::CFG_PERIOD:    cfg_next.step_period       = cfg_data[30:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lsp_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .vel_x    (vel_x),
        .vel_y    (vel_y),
        .now_time (now_time),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    lsp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    lsp_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    lsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .mul_req    (mul_req),
        .mul_rsp    (mul_rsp),
        .sqrt_req   (sqrt_req),
        .sqrt_rsp   (sqrt_rsp),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .setpoint_x (setpoint_x),
        .setpoint_y (setpoint_y)
    );

endmodule

/* design/lsp_checker.sv */
// Port-level checker of the landing setpoint predictor, bound to the top level.
`include "landing_setpoint_predictor_macros.svh"

module lsp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic signed [31:0]              setpoint_x,
    input logic signed [31:0]              setpoint_y,
    input logic                            cfg_ready
);

    // A stalled result holds
    `LSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(setpoint_x) && $stable(setpoint_y), "stalled setpoint changed")

    // Configuration writes are always taken
    `LSP_ASSERT_NOW(a_cfg_ready, cfg_ready, "configuration port not ready")

    // Reset empties the queue and the result register
    `LSP_ASSERT_RESET(a_reset_empty, !out_valid && !in_stall, "state not cleared by reset")

endmodule

bind landing_setpoint_predictor lsp_checker u_checker (.*);
